/* src/mlqs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types and constants for the multilevel queue slot scheduler.
// ----------------------------------------------------------------------------
package mlqs_pkg;

   localparam int DEF_LEVELS      = 16;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int HANDLE_W        = 16;
   localparam int LEVEL_W         = 4;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   typedef struct packed {
      logic                action;
      logic [LEVEL_W-1:0]  level;
      logic [HANDLE_W-1:0] task_handle;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DONE
   } back_state_type;

endpackage

/* src/mlqs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlqs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mlqs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_front
// Input stage: takes request transfers into a two-entry command queue.
// ----------------------------------------------------------------------------
module mlqs_front import mlqs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

/* src/mlqs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_back
// Execution stage: per-level FIFO bookkeeping, credit scan, handle store
// access and the result register.
// ----------------------------------------------------------------------------
module mlqs_back import mlqs_pkg::*; #(
   parameter int LEVELS      = DEF_LEVELS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  cmd_type             cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_granted,
   output logic [HANDLE_W-1:0] rsp_handle,
   output logic [LEVEL_W-1:0]  rsp_level,
   output logic                rsp_overflow,
   output logic                rsp_all_empty
);

   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int KW = $clog2(LEVELS + 1);
   localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);

   logic [PW-1:0] head_ff [LEVELS];
   logic [PW-1:0] tail_ff [LEVELS];
   logic [CW-1:0] fill_ff [LEVELS];
   logic [KW-1:0] credit_ff [LEVELS];

   back_state_type state_ff, state_in;

   logic          granted_ff, overflow_ff, empty_ff, valid_ff;
   logic [LEVEL_W-1:0] olevel_ff;
   logic [HANDLE_W-1:0] rd_handle_ff;

   logic          take;
   logic          lvl_ok;
   logic [LW-1:0] elvl;
   logic          found;
   logic [LW-1:0] win;
   logic [LEVELS-1:0] elig;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [HANDLE_W-1:0] rd_data;
   logic          nz_after;

   assign cmd_ready = (state_ff == ST_IDLE) && !valid_ff;
   assign take      = cmd_valid && cmd_ready;
   assign elvl      = LW'(cmd.level);
   assign lvl_ok    = ({{(32-LEVEL_W){1'b0}}, cmd.level} < 32'(LEVELS))
                      && (fill_ff[elvl] < CW'(QUEUE_DEPTH));

   always_comb begin
      found = 1'b0;
      win   = '0;
      for (int i = 0; i < LEVELS; i++) begin
         elig[i] = (fill_ff[i] != '0) && (credit_ff[i] != '0);
      end
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (elig[i]) begin
            found = 1'b1;
            win   = LW'(i);
         end
      end
   end

   assign wr_en   = take && (cmd.action == ACT_ENQUEUE) && lvl_ok;
   assign wr_addr = AW'(32'(elvl) * QUEUE_DEPTH + 32'(tail_ff[elvl]));
   assign rd_addr = AW'(32'(win) * QUEUE_DEPTH + 32'(head_ff[win]));

   mlqs_ram #(.WIDTH(HANDLE_W), .DEPTH(LEVELS * QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.task_handle),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      nz_after = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
         if (fill_ff[i] != '0) begin
            nz_after = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= 1'b0;
         granted_ff  <= 1'b0;
         overflow_ff <= 1'b0;
         olevel_ff   <= '0;
         empty_ff    <= 1'b1;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]   <= '0;
            tail_ff[i]   <= '0;
            fill_ff[i]   <= '0;
            credit_ff[i] <= KW'(LEVELS - i);
         end
      end else begin
         state_ff <= state_in;
         if (take) begin
            granted_ff  <= 1'b0;
            overflow_ff <= 1'b0;
            olevel_ff   <= '0;
            if (cmd.action == ACT_ENQUEUE) begin
               if (lvl_ok) begin
                  tail_ff[elvl] <= (tail_ff[elvl] == PW'(QUEUE_DEPTH - 1)) ? '0
                                   : tail_ff[elvl] + 1'b1;
                  fill_ff[elvl] <= fill_ff[elvl] + 1'b1;
               end else begin
                  overflow_ff <= 1'b1;
               end
            end else begin
               for (int i = 0; i < LEVELS; i++) begin
                  if (!elig[i] && (!found || LW'(i) < win)) begin
                     credit_ff[i] <= KW'(LEVELS - i);
                  end
               end
               if (found) begin
                  granted_ff     <= 1'b1;
                  olevel_ff      <= LEVEL_W'(win);
                  head_ff[win]   <= (head_ff[win] == PW'(QUEUE_DEPTH - 1)) ? '0
                                    : head_ff[win] + 1'b1;
                  fill_ff[win]   <= fill_ff[win] - 1'b1;
                  credit_ff[win] <= credit_ff[win] - 1'b1;
               end
            end
         end
         if (state_ff == ST_READ) begin
            empty_ff <= !nz_after;
         end
         if (state_ff == ST_DONE) begin
            valid_ff <= 1'b1;
         end else if (rsp_valid && rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_handle_ff <= rd_data;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_granted   = granted_ff;
   assign rsp_handle    = granted_ff ? rd_handle_ff : '0;
   assign rsp_level     = olevel_ff;
   assign rsp_overflow  = overflow_ff;
   assign rsp_all_empty = empty_ff;

endmodule

/* src/multilevel_queue_slot_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_slot_scheduler_unit
// Multilevel queue scheduler with per-level slot credits.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata fields (low bit up)
// req      in   action[0], level[4:1], task_handle[20:5], zero[23:21]
// rsp      out  granted[0], out_handle[16:1], out_level[20:17],
//               overflow[21], all_empty[22], zero[23]
//
// Each item passes through the back-end states in order: scan and state update,
// handle store read and capture, result release. The response transfer follows
// and the next command is taken after it, so the back end takes no new item
// before the last is through. A two-entry command queue takes transfers
// meanwhile. Reset is synchronous and restores pointers, counts and credits
// at once. A stalled result holds the back end until it is taken.
// ----------------------------------------------------------------------------
module multilevel_queue_slot_scheduler_unit import mlqs_pkg::*; #(
   parameter int LEVELS      = DEF_LEVELS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // action, level, task_handle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // granted, out_handle, out_level, overflow, all_empty
);

   cmd_type in_cmd, q_cmd;
   logic    q_valid, q_ready;
   logic    granted, overflow, all_empty;
   logic [HANDLE_W-1:0] handle;
   logic [LEVEL_W-1:0]  olevel;
   logic    unused_pad;

   assign in_cmd.action      = req_tdata[0];
   assign in_cmd.level       = req_tdata[4:1];
   assign in_cmd.task_handle = req_tdata[20:5];
   assign unused_pad         = ^req_tdata[23:21];

   mlqs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (in_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   mlqs_back #(.LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd_ready     (q_ready),
      .cmd           (q_cmd),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_granted   (granted),
      .rsp_handle    (handle),
      .rsp_level     (olevel),
      .rsp_overflow  (overflow),
      .rsp_all_empty (all_empty)
   );

   assign rsp_tdata = {unused_pad & 1'b0, all_empty, overflow, olevel, handle, granted};

endmodule
